// ----- design/assert_macros.svh -----
// Assertion macros shared by the quadratic root solver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define QRS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define QRS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/qrs_pkg.sv -----
// Shared constants and types for the quadratic root solver.
package qrs_pkg;

  // Width of each reported root (signed, with the fraction bits inside).
  localparam int OUT_W = 48;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_TWO   = 2'd0,
    ST_ONE   = 2'd1,
    ST_NONE  = 2'd2,
    ST_DEGEN = 2'd3
  } status_t;

endpackage

// ----- design/qrs_req_if.sv -----
// Request channel carrying one set of coefficients per transaction.
interface qrs_req_if #(
  parameter int COEF_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COEF_WIDTH-1:0] coef_a;
  logic signed [COEF_WIDTH-1:0] coef_b;
  logic signed [COEF_WIDTH-1:0] coef_c;

  modport source (output valid, mode, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, mode, coef_a, coef_b, coef_c, output ready);
endinterface

// ----- design/qrs_rsp_if.sv -----
// Response channel carrying one root result per transaction.
interface qrs_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      root_status;
  logic signed [qrs_pkg::OUT_W-1:0] root_one;
  logic signed [qrs_pkg::OUT_W-1:0] root_two;
  logic                            saturated;

  modport source (output valid, root_status, root_one, root_two, saturated, input ready);
  modport sink (input valid, root_status, root_one, root_two, saturated, output ready);
endinterface

// ----- design/quadratic_root_solver.sv -----
// Pipelined real-root solver for quadratic and linear equations.
//
//   channel | dir | payload
//   --------+-----+------------------------------------------------------
//   req     | in  | mode, coef_a, coef_b, coef_c
//   rsp     | out | root_status, root_one, root_two, saturated
//
// One transaction enters per cycle while req.ready is high. The stages are:
// products, discriminant, one square-root bit per stage, numerator forming,
// one quotient bit per stage, output register.
// Reset (rst, synchronous) clears only the valid bits of the stages and of the output and skid registers.
// A stalled response is held in the output register and one more result is
// caught in a skid register; req.ready drops only while that skid is full.
module quadratic_root_solver #(
  parameter int COEF_WIDTH     = 16,
  parameter int ROOT_FRAC_BITS = 16
) (
  input logic        clk,
  input logic        rst,
  qrs_req_if.sink    req,
  qrs_rsp_if.source  rsp
);

  `include "assert_macros.svh"

  localparam int W     = COEF_WIDTH;
  localparam int R     = ROOT_FRAC_BITS;
  localparam int OUT_W = qrs_pkg::OUT_W;
  localparam int PW    = 2 * W;
  localparam int DW    = 2 * W + 2;
  localparam int SW    = W + 1;
  localparam int QW    = W + 1 + R;
  localparam int EW    = ((QW > OUT_W) ? QW : OUT_W) + 1;
  localparam int NS    = SW + QW + 3;
  localparam logic [EW-1:0] NEG_MAG = EW'(1) << (OUT_W - 1);
  localparam logic [EW-1:0] POS_MAX = NEG_MAG - EW'(1);

  typedef struct packed {
    logic                mode;
    qrs_pkg::status_t    status;
    logic signed [W-1:0] a;
    logic signed [W-1:0] b;
  } meta_t;

  typedef struct packed {
    logic             sat;
    logic [OUT_W-1:0] root;
  } fmt_t;

  // Clip a quotient magnitude to the output range and apply its sign.
  function automatic fmt_t fmt_root(input logic [QW-1:0] q, input logic neg);
    logic [EW-1:0] qe;
    logic [EW-1:0] lim;
    logic [EW-1:0] qc;
    logic [EW-1:0] val;
    fmt_t          res;
    qe       = EW'(q);
    lim      = neg ? NEG_MAG : POS_MAX;
    res.sat  = (qe > lim);
    qc       = res.sat ? lim : qe;
    val      = neg ? (EW'(0) - qc) : qc;
    res.root = val[OUT_W-1:0];
    return res;
  endfunction

  logic          en;
  logic          skid_v;
  logic [NS-1:0] v;
  meta_t         meta [NS];

  // Stage valid bits shift together while the skid register is free.
  assign en        = !skid_v;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], req.valid};
    end
  end

  // Stage P: the two products b*b and a*c.
  logic signed [PW-1:0] p_bb;
  logic signed [PW-1:0] p_ac;

  always_ff @(posedge clk) begin
    if (en) begin
      p_bb    <= req.coef_b * req.coef_b;
      p_ac    <= req.coef_a * req.coef_c;
      meta[0] <= '{mode: req.mode, status: qrs_pkg::ST_TWO, a: req.coef_a, b: req.coef_b};
    end
  end

  // Stage D: discriminant and the result status.
  logic signed [DW-1:0] dd;
  qrs_pkg::status_t     d_status;
  logic [DW-1:0]        d_x;

  always_comb begin
    dd = DW'(p_bb) - (DW'(p_ac) <<< 2);
    if (meta[0].mode) begin
      d_status = (meta[0].a == '0) ? qrs_pkg::ST_NONE : qrs_pkg::ST_ONE;
    end else if (meta[0].a == '0) begin
      d_status = qrs_pkg::ST_DEGEN;
    end else if (dd < 0) begin
      d_status = qrs_pkg::ST_NONE;
    end else if (dd == '0) begin
      d_status = qrs_pkg::ST_ONE;
    end else begin
      d_status = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_x     <= dd[DW-1] ? '0 : dd;
      meta[1] <= '{mode: meta[0].mode, status: d_status, a: meta[0].a, b: meta[0].b};
    end
  end

  // Metadata travels unchanged through the remaining stages.
  for (genvar k = 2; k < NS; k++) begin : g_meta
    always_ff @(posedge clk) begin
      if (en) begin
        meta[k] <= meta[k-1];
      end
    end
  end

  // Square-root stages: one result bit per stage, two radicand bits consumed.
  logic [SW+1:0] sq_rem  [SW];
  logic [SW-1:0] sq_root [SW];
  logic [DW-1:0] sq_x    [SW];

  for (genvar j = 0; j < SW; j++) begin : g_sqrt
    logic [DW-1:0] x_in;
    logic [SW+1:0] rem_in;
    logic [SW-1:0] root_in;
    logic [SW+1:0] t;
    logic [SW+1:0] trial;

    if (j == 0) begin : g_first
      assign x_in    = d_x;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = sq_x[j-1];
      assign rem_in  = sq_rem[j-1];
      assign root_in = sq_root[j-1];
    end

    assign t     = {rem_in[SW-1:0], x_in[DW-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        sq_x[j] <= {x_in[DW-3:0], 2'b00};
        if (t >= trial) begin
          sq_rem[j]  <= t - trial;
          sq_root[j] <= {root_in[SW-2:0], 1'b1};
        end else begin
          sq_rem[j]  <= t;
          sq_root[j] <= {root_in[SW-2:0], 1'b0};
        end
      end
    end
  end

  // Stage N: numerator and denominator magnitudes with the quotient signs.
  logic [W+1:0] n_nb;
  logic [W+1:0] n_one;
  logic [W+1:0] n_two;
  logic [W:0]   n_den;
  logic [W:0]   n_m1;
  logic [W:0]   n_m2;
  logic [W:0]   n_dm;
  logic         n_neg1;
  logic         n_neg2;

  always_comb begin
    n_nb  = (W+2)'(0) - (W+2)'(meta[SW+1].b);
    if (meta[SW+1].mode) begin
      n_one = n_nb;
      n_two = n_nb;
      n_den = (W+1)'(meta[SW+1].a);
    end else begin
      n_one = n_nb + {1'b0, sq_root[SW-1]};
      n_two = n_nb - {1'b0, sq_root[SW-1]};
      n_den = {meta[SW+1].a, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_m1   <= n_one[W+1] ? (W+1)'((W+2)'(0) - n_one) : n_one[W:0];
      n_m2   <= n_two[W+1] ? (W+1)'((W+2)'(0) - n_two) : n_two[W:0];
      n_dm   <= n_den[W] ? ((W+1)'(0) - n_den) : n_den;
      n_neg1 <= n_one[W+1] ^ n_den[W];
      n_neg2 <= n_two[W+1] ^ n_den[W];
    end
  end

  // Divider stages: one restoring quotient bit per stage for both roots.
  logic [W:0]    dv_rem1 [QW];
  logic [W:0]    dv_rem2 [QW];
  logic [QW-1:0] dv_q1   [QW];
  logic [QW-1:0] dv_q2   [QW];
  logic [W:0]    dv_dm   [QW];
  logic          dv_neg1 [QW];
  logic          dv_neg2 [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [W:0]    rem1_in;
    logic [W:0]    rem2_in;
    logic [QW-1:0] q1_in;
    logic [QW-1:0] q2_in;
    logic [W:0]    dm_in;
    logic          neg1_in;
    logic          neg2_in;
    logic [W+1:0]  t1;
    logic [W+1:0]  t2;
    logic          ge1;
    logic          ge2;

    if (j == 0) begin : g_first
      assign rem1_in = '0;
      assign rem2_in = '0;
      assign q1_in   = {n_m1, R'(0)};
      assign q2_in   = {n_m2, R'(0)};
      assign dm_in   = n_dm;
      assign neg1_in = n_neg1;
      assign neg2_in = n_neg2;
    end else begin : g_next
      assign rem1_in = dv_rem1[j-1];
      assign rem2_in = dv_rem2[j-1];
      assign q1_in   = dv_q1[j-1];
      assign q2_in   = dv_q2[j-1];
      assign dm_in   = dv_dm[j-1];
      assign neg1_in = dv_neg1[j-1];
      assign neg2_in = dv_neg2[j-1];
    end

    assign t1  = {rem1_in, q1_in[QW-1]};
    assign t2  = {rem2_in, q2_in[QW-1]};
    assign ge1 = (t1 >= {1'b0, dm_in});
    assign ge2 = (t2 >= {1'b0, dm_in});

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem1[j] <= ge1 ? (W+1)'(t1 - {1'b0, dm_in}) : t1[W:0];
        dv_rem2[j] <= ge2 ? (W+1)'(t2 - {1'b0, dm_in}) : t2[W:0];
        dv_q1[j]   <= {q1_in[QW-2:0], ge1};
        dv_q2[j]   <= {q2_in[QW-2:0], ge2};
        dv_dm[j]   <= dm_in;
        dv_neg1[j] <= neg1_in;
        dv_neg2[j] <= neg2_in;
      end
    end
  end

  // Final formatting: clip, sign, and zero the roots when there are none.
  fmt_t             f_one;
  fmt_t             f_two;
  logic             f_zero;
  logic [1:0]       f_status;
  logic [OUT_W-1:0] f_root1;
  logic [OUT_W-1:0] f_root2;
  logic             f_sat;
  logic             produced;

  always_comb begin
    f_one    = fmt_root(dv_q1[QW-1], dv_neg1[QW-1]);
    f_two    = fmt_root(dv_q2[QW-1], dv_neg2[QW-1]);
    f_zero   = (meta[NS-1].status == qrs_pkg::ST_NONE) ||
               (meta[NS-1].status == qrs_pkg::ST_DEGEN);
    f_status = meta[NS-1].status;
    f_root1  = f_zero ? '0 : f_one.root;
    f_root2  = f_zero ? '0 : f_two.root;
    f_sat    = !f_zero && (f_one.sat || f_two.sat);
    produced = en && v[NS-1];
  end

  // Output register with a one-entry skid behind it.
  logic             out_v;
  logic [1:0]       out_status;
  logic [OUT_W-1:0] out_root1;
  logic [OUT_W-1:0] out_root2;
  logic             out_sat;
  logic [1:0]       skid_status;
  logic [OUT_W-1:0] skid_root1;
  logic [OUT_W-1:0] skid_root2;
  logic             skid_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (out_v && !rsp.ready) begin
      if (produced) begin
        skid_v <= 1'b1;
      end
    end else if (skid_v) begin
      out_v  <= 1'b1;
      skid_v <= 1'b0;
    end else begin
      out_v <= produced;
    end
  end

  always_ff @(posedge clk) begin
    if (out_v && !rsp.ready) begin
      if (produced) begin
        skid_status <= f_status;
        skid_root1  <= f_root1;
        skid_root2  <= f_root2;
        skid_sat    <= f_sat;
      end
    end else if (skid_v) begin
      out_status <= skid_status;
      out_root1  <= skid_root1;
      out_root2  <= skid_root2;
      out_sat    <= skid_sat;
    end else if (produced) begin
      out_status <= f_status;
      out_root1  <= f_root1;
      out_root2  <= f_root2;
      out_sat    <= f_sat;
    end
  end

  assign rsp.valid       = out_v;
  assign rsp.root_status = out_status;
  assign rsp.root_one    = out_root1;
  assign rsp.root_two    = out_root2;
  assign rsp.saturated   = out_sat;

  // Checks on the result encoding and the stall path.
  `QRS_ASSERT_IMPLY(a_no_root_zero,
    out_v && ((out_status == qrs_pkg::ST_NONE) || (out_status == qrs_pkg::ST_DEGEN)),
    (out_root1 == '0) && (out_root2 == '0) && !out_sat,
    "root reported for a transaction without real roots")
  `QRS_ASSERT_IMPLY(a_one_root_equal,
    out_v && (out_status == qrs_pkg::ST_ONE),
    out_root1 == out_root2,
    "single-root transaction has two different roots")
  `QRS_ASSERT_IMPLY(a_skid_needs_out, skid_v, out_v,
    "skid register holds a result while the output register is empty")
  `QRS_ASSERT_NEXT(a_skid_holds, skid_v && !rsp.ready, skid_v,
    "skid register dropped a result during a stall")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the quadratic root solver.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 16;
  localparam int FRAC = 16;
  localparam longint POS_MAX = (64'sd1 <<< (qrs_pkg::OUT_W - 1)) - 1;
  localparam longint NEG_MAG = 64'sd1 <<< (qrs_pkg::OUT_W - 1);
  localparam int LATENCY = 2 * CW + FRAC + 6;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic                 mode;
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coef_set_t;

  typedef struct {
    qrs_pkg::status_t                 status;
    logic signed [qrs_pkg::OUT_W-1:0] r1;
    logic signed [qrs_pkg::OUT_W-1:0] r2;
    logic                             sat;
  } roots_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qrs_req_if #(.COEF_WIDTH(CW)) req ();
  qrs_rsp_if rsp ();

  quadratic_root_solver #(.COEF_WIDTH(CW), .ROOT_FRAC_BITS(FRAC)) uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];
  int        total_sets;
  int        sent_count = 0;
  int        error_count = 0;
  int        cycle_count = 0;
  bit        req_fired = 1'b0;

  // Clock generation.
  always #5 clk = ~clk;

  // Floor square root by the bit-pair method.
  function automatic longint floor_sqrt(longint x);
    longint r;
    longint step;
    r = 0;
    step = 64'sd1 <<< 62;
    while (step > x) step = step >>> 2;
    while (step != 0) begin
      if (x >= r + step) begin
        x = x - (r + step);
        r = (r >>> 1) + step;
      end else begin
        r = r >>> 1;
      end
      step = step >>> 2;
    end
    return r;
  endfunction

  // Quotient num * 2^FRAC / den truncated toward zero, clipped to the root range.
  function automatic logic [qrs_pkg::OUT_W-1:0] div_clip(longint num, longint den,
                                                         inout bit sat);
    bit     neg;
    longint q;
    longint nq;
    neg = (num < 0) != (den < 0);
    q = ((num < 0 ? -num : num) <<< FRAC) / (den < 0 ? -den : den);
    if (!neg) begin
      if (q > POS_MAX) begin
        sat = 1'b1;
        q = POS_MAX;
      end
      return q[qrs_pkg::OUT_W-1:0];
    end
    if (q > NEG_MAG) begin
      sat = 1'b1;
      q = NEG_MAG;
    end
    nq = -q;
    return nq[qrs_pkg::OUT_W-1:0];
  endfunction

  // Expected roots for one coefficient set.
  function automatic roots_t solve_roots(coef_set_t cs);
    roots_t res;
    longint a, b, c, disc, s;
    bit     sat;
    a = cs.a;
    b = cs.b;
    c = cs.c;
    sat = 1'b0;
    res.r1 = '0;
    res.r2 = '0;
    if (cs.mode) begin
      if (a == 0) begin
        res.status = qrs_pkg::ST_NONE;
      end else begin
        res.status = qrs_pkg::ST_ONE;
        res.r1 = div_clip(-b, a, sat);
        res.r2 = res.r1;
      end
    end else if (a == 0) begin
      res.status = qrs_pkg::ST_DEGEN;
    end else begin
      disc = b * b - 4 * a * c;
      if (disc < 0) begin
        res.status = qrs_pkg::ST_NONE;
      end else begin
        s = floor_sqrt(disc);
        res.status = (disc == 0) ? qrs_pkg::ST_ONE : qrs_pkg::ST_TWO;
        res.r1 = div_clip(-b + s, 2 * a, sat);
        res.r2 = div_clip(-b - s, 2 * a, sat);
      end
    end
    res.sat = sat;
    return res;
  endfunction

  function automatic coef_set_t make_set(logic m, int a, int b, int c);
    coef_set_t cs;
    cs.mode = m;
    cs.a = CW'(a);
    cs.b = CW'(b);
    cs.c = CW'(c);
    return cs;
  endfunction

  // Coefficient drawn from extremes, small or medium values, or the full range.
  function automatic int pick_coef();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return $urandom_range(1) ? 32767 : -32768;
    if (sel < 4) return $signed($urandom_range(32)) - 16;
    if (sel < 6) return $signed($urandom_range(2048)) - 1024;
    return $signed($urandom_range(65535)) - 32768;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Stimulus: directed corner cases, then random sets.
  initial begin
    int r, k;
    pending_sets.push_back(make_set(1'b0, 0, 5, 7));
    pending_sets.push_back(make_set(1'b0, 0, 0, 0));
    pending_sets.push_back(make_set(1'b0, 256, 0, 256));
    pending_sets.push_back(make_set(1'b0, 256, 512, 256));
    pending_sets.push_back(make_set(1'b0, 256, -768, 512));
    pending_sets.push_back(make_set(1'b0, 1, 1, 0));
    pending_sets.push_back(make_set(1'b0, 4, 4, 1));
    pending_sets.push_back(make_set(1'b0, 2, 3, 1));
    pending_sets.push_back(make_set(1'b0, -32768, -32768, -32768));
    pending_sets.push_back(make_set(1'b0, 32767, 32767, -32768));
    pending_sets.push_back(make_set(1'b0, -32768, 32767, 32767));
    pending_sets.push_back(make_set(1'b0, 1, -32768, 32767));
    pending_sets.push_back(make_set(1'b0, -1, 32767, 32767));
    pending_sets.push_back(make_set(1'b0, 32767, 32767, 32767));
    pending_sets.push_back(make_set(1'b1, 0, 100, 3));
    pending_sets.push_back(make_set(1'b1, 256, -512, 0));
    pending_sets.push_back(make_set(1'b1, 1, -32768, 5));
    pending_sets.push_back(make_set(1'b1, -1, -32768, -5));
    pending_sets.push_back(make_set(1'b1, 1, 32767, 0));
    pending_sets.push_back(make_set(1'b1, -32768, 32767, 32767));
    pending_sets.push_back(make_set(1'b1, 32767, -32768, -32768));
    for (int i = 0; i < 550; i++) begin
      if ($urandom_range(5) == 0) begin
        // Double root: b = -2ar and c = ar^2 give a zero discriminant.
        k = $signed($urandom_range(60)) - 30;
        r = $signed($urandom_range(20)) - 10;
        pending_sets.push_back(make_set(1'b0, k, -2 * k * r, k * r * r));
      end else if ($urandom_range(9) == 0) begin
        pending_sets.push_back(make_set(1'($urandom_range(1)), 0, pick_coef(),
                                        pick_coef()));
      end else begin
        pending_sets.push_back(make_set(1'($urandom_range(1)), pick_coef(), pick_coef(),
                                        pick_coef()));
      end
    end
    total_sets = pending_sets.size();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_sets.size() == 0 && !req.valid && expected_roots.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && expected_roots.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Driver: presents the next set at the falling edge, with random gaps and random response stalls.
  always @(negedge clk) begin
    int idle_pct;
    int stall_pct;
    coef_set_t cs;
    if (sent_count < total_sets / 3) begin
      idle_pct = 25;
      stall_pct = 60;
    end else if (sent_count < 2 * total_sets / 3) begin
      idle_pct = 60;
      stall_pct = 25;
    end else begin
      idle_pct = 0;
      stall_pct = 0;
    end
    if (rst) begin
      req.valid <= 1'b0;
      req.mode <= 1'b0;
      req.coef_a <= '0;
      req.coef_b <= '0;
      req.coef_c <= '0;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
      if (!req.valid || req_fired) begin
        if (pending_sets.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cs = pending_sets.pop_front();
          req.valid <= 1'b1;
          req.mode <= cs.mode;
          req.coef_a <= cs.a;
          req.coef_b <= cs.b;
          req.coef_c <= cs.c;
          sent_count++;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: records accepted sets and checks each response transaction.
  always @(posedge clk) begin
    coef_set_t cs;
    roots_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      req_fired = !rst && req.valid && req.ready;
      if (req_fired) begin
        cs.mode = req.mode;
        cs.a = req.coef_a;
        cs.b = req.coef_b;
        cs.c = req.coef_c;
        expected_roots.push_back(solve_roots(cs));
      end
      if (!rst && rsp.valid && rsp.ready) begin
        if (expected_roots.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          want = expected_roots.pop_front();
          if (rsp.root_status !== want.status)
            report_mismatch("root_status", rsp.root_status, want.status);
          if (rsp.root_one !== want.r1)
            report_mismatch("root_one", rsp.root_one, want.r1);
          if (rsp.root_two !== want.r2)
            report_mismatch("root_two", rsp.root_two, want.r2);
          if (rsp.saturated !== want.sat)
            report_mismatch("saturated", rsp.saturated, want.sat);
        end
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/qrs_pkg.sv
design/qrs_req_if.sv
design/qrs_rsp_if.sv
design/quadratic_root_solver.sv
tb/sv/tb_top.sv
